[design/salc_pkg.sv]
// Shared codes and types for the set-associative LRU cache controller.
`timescale 1ns / 1ps
package salc_pkg;

  localparam int unsigned WAY_IDX_W = 4;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_STORE = 2'd1,
    FUNC_FETCH = 2'd2,
    FUNC_FLUSH = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    REG_SPLIT_MODE  = 3'd0,
    REG_WAYS        = 3'd1,
    REG_OFFSET_BITS = 3'd2,
    REG_DATA_SETS   = 3'd3,
    REG_INSTR_SETS  = 3'd4,
    REG_WRITE_BACK  = 3'd5,
    REG_WRITE_ALLOC = 3'd6,
    REG_NONE        = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic                 found;
    logic [WAY_IDX_W-1:0] hit_way;
    logic                 inv_found;
    logic [WAY_IDX_W-1:0] inv_way;
    logic [WAY_IDX_W-1:0] best_way;
  } scan_res_t;

endpackage

[design/set_assoc_lru_cache_controller.sv]
// Top level: config registers, access and flush sequencer, result register.
//
//  channel  direction  handshake                     payload
//  in       to block   in_valid_i / in_stall_o       func_i, addr_i
//  out      from block out_valid_o / out_stall_i     hit_o miss_o replaced_o fetched_o
//                                                    copy_back_words_o
//  cfg      to block   APB psel/penable/pready       paddr pwdata prdata
//
// Access: accept, read, a scan step per way in use, done flag, update, result.
// Flush: accept, a pass over all 2^(MAX_SET_BITS+1) rows, sum, multiply, result.
// After reset a clearing pass over all 2^(MAX_SET_BITS+1) rows runs before the first
// transfer is taken. A stalled result holds the block; no item is taken meanwhile.
`timescale 1ns / 1ps
module set_assoc_lru_cache_controller #(
  parameter int unsigned MAX_WAYS        = 8,
  parameter int unsigned MAX_SET_BITS    = 10,
  parameter int unsigned ADDR_BITS       = 32,
  parameter int unsigned WORD_BYTES      = 4,
  parameter int unsigned MAX_OFFSET_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           func_i,
  input  logic [ADDR_BITS-1:0] addr_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 hit_o,
  output logic                 miss_o,
  output logic                 replaced_o,
  output logic                 fetched_o,
  output logic [20:0]          copy_back_words_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import salc_pkg::*;

  localparam int unsigned SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned ROW_W  = SET_W + 1;
  localparam int unsigned WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned NW_W   = $clog2(MAX_WAYS + 1);
  localparam int unsigned RANK_W = NW_W;
  localparam int unsigned TAG_W  = ADDR_BITS - 2;
  localparam int unsigned ENT_W  = TAG_W + RANK_W + 2;
  localparam int unsigned ROW_D  = MAX_WAYS * ENT_W;
  localparam int unsigned BW_W   = MAX_OFFSET_BITS + 1;
  localparam int unsigned CNT_W  = ROW_W + NW_W;
  localparam int unsigned PROD_W = CNT_W + BW_W;

  function automatic logic [(MAX_OFFSET_BITS+1)*BW_W-1:0] bw_tab_f();
    logic [(MAX_OFFSET_BITS+1)*BW_W-1:0] t;
    t = '0;
    for (int i = 0; i <= MAX_OFFSET_BITS; i++) begin
      t[i*BW_W +: BW_W] = BW_W'((64'd1 << i) / WORD_BYTES);
    end
    return t;
  endfunction

  localparam logic [(MAX_OFFSET_BITS+1)*BW_W-1:0] BW_TAB = bw_tab_f();

  typedef enum logic [8:0] {
    ST_CLEAR     = 9'b000000001,
    ST_IDLE      = 9'b000000010,
    ST_READ      = 9'b000000100,
    ST_SCAN      = 9'b000001000,
    ST_UPDATE    = 9'b000010000,
    ST_FLUSH     = 9'b000100000,
    ST_FLUSH_END = 9'b001000000,
    ST_MUL       = 9'b010000000,
    ST_OUT       = 9'b100000000
  } state_e;

  // configuration
  logic       split_q, wb_q, wa_q;
  logic [3:0] ways_q, ob_q, dsb_q, isb_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_q <= 1'b0;
      ways_q  <= 4'd1;
      ob_q    <= 4'd2;
      dsb_q   <= 4'd10;
      isb_q   <= 4'd10;
      wb_q    <= 1'b1;
      wa_q    <= 1'b1;
    end else if (cfg_we) begin
      unique case (reg_idx_e'(paddr[4:2]))
        REG_SPLIT_MODE:  split_q <= pwdata[0];
        REG_WAYS:        ways_q  <= pwdata[3:0];
        REG_OFFSET_BITS: ob_q    <= pwdata[3:0];
        REG_DATA_SETS:   dsb_q   <= pwdata[3:0];
        REG_INSTR_SETS:  isb_q   <= pwdata[3:0];
        REG_WRITE_BACK:  wb_q    <= pwdata[0];
        REG_WRITE_ALLOC: wa_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[4:2]))
      REG_SPLIT_MODE:  prdata = {31'd0, split_q};
      REG_WAYS:        prdata = {28'd0, ways_q};
      REG_OFFSET_BITS: prdata = {28'd0, ob_q};
      REG_DATA_SETS:   prdata = {28'd0, dsb_q};
      REG_INSTR_SETS:  prdata = {28'd0, isb_q};
      REG_WRITE_BACK:  prdata = {31'd0, wb_q};
      REG_WRITE_ALLOC: prdata = {31'd0, wa_q};
      default:         prdata = '0;
    endcase
  end

  // effective settings
  logic [NW_W-1:0] nw;
  logic [3:0]      ob;
  logic [BW_W-1:0] bw;

  always_comb begin
    if (ways_q == 4'd0) begin
      nw = NW_W'(1);
    end else if (32'(ways_q) > MAX_WAYS) begin
      nw = NW_W'(MAX_WAYS);
    end else begin
      nw = NW_W'(ways_q);
    end
    if (ob_q < 4'd2) begin
      ob = 4'd2;
    end else if (32'(ob_q) > MAX_OFFSET_BITS) begin
      ob = 4'(MAX_OFFSET_BITS);
    end else begin
      ob = ob_q;
    end
    bw = BW_TAB[ob*BW_W +: BW_W];
  end

  // sequencer state
  state_e               state_q, state_d;
  logic [1:0]           func_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic [TAG_W-1:0]     tag_q, tag_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [ROW_W-1:0]     ctr_q, ctr_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 hit_q, miss_q, repl_q, fetch_q;
  logic                 hit_d, miss_d, repl_d, fetch_d;
  logic [20:0]          words_q, words_d;

  logic                 re, we;
  logic [ROW_W-1:0]     raddr, waddr;
  logic [ROW_D-1:0]     rdata, wdata, upd_row;
  logic                 scan_start, scan_done;
  scan_res_t            sres;

  // address split
  logic                 half;
  logic [3:0]           sb_raw;
  logic [4:0]           sb;
  logic [ADDR_BITS-1:0] sh_set, sh_tag;
  logic [SET_W-1:0]     set_idx;

  always_comb begin
    half   = (func_e'(func_q) == FUNC_FETCH) && split_q;
    sb_raw = half ? isb_q : dsb_q;
    sb     = (32'(sb_raw) > MAX_SET_BITS) ? 5'(MAX_SET_BITS) : {1'b0, sb_raw};
    sh_set = addr_q >> ob;
    sh_tag = addr_q >> ({2'b0, ob} + {1'b0, sb});
    set_idx = sh_set[SET_W-1:0] & ~({SET_W{1'b1}} << sb);
  end

  // row update for a load, store or fetch
  logic [WAY_W-1:0]  uw;
  logic [RANK_W-1:0] ur;
  logic              is_store, do_write;
  logic [BW_W:0]     acc_words;
  logic [NW_W:0]     dirty_cnt;

  always_comb begin
    is_store  = (func_e'(func_q) == FUNC_STORE);
    upd_row   = rdata;
    hit_d     = 1'b0;
    miss_d    = 1'b0;
    repl_d    = 1'b0;
    fetch_d   = 1'b0;
    acc_words = '0;
    do_write  = 1'b1;
    uw        = sres.hit_way[WAY_W-1:0];
    ur        = rdata[uw*ENT_W + TAG_W +: RANK_W];
    if (sres.found) begin
      hit_d = 1'b1;
      if (is_store) begin
        if (wb_q) begin
          upd_row[uw*ENT_W + ENT_W - 2] = 1'b1;
        end else begin
          acc_words = (BW_W+1)'(1);
        end
      end
    end else begin
      miss_d = 1'b1;
      if (is_store && !wa_q) begin
        acc_words = (BW_W+1)'(1);
        do_write  = 1'b0;
      end else begin
        fetch_d = 1'b1;
        if (sres.inv_found) begin
          uw = sres.inv_way[WAY_W-1:0];
          ur = RANK_W'(nw);
        end else begin
          uw     = sres.best_way[WAY_W-1:0];
          ur     = rdata[uw*ENT_W + TAG_W +: RANK_W];
          repl_d = 1'b1;
          if (rdata[uw*ENT_W + ENT_W - 2]) begin
            acc_words = {1'b0, bw};
          end
        end
        upd_row[uw*ENT_W +: TAG_W]  = tag_q;
        upd_row[uw*ENT_W + ENT_W - 1] = 1'b1;
        upd_row[uw*ENT_W + ENT_W - 2] = is_store && wb_q;
        if (is_store && !wb_q) begin
          acc_words = acc_words + (BW_W+1)'(1);
        end
      end
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (NW_W'(i) < nw && WAY_W'(i) != uw && rdata[i*ENT_W + ENT_W - 1]
          && rdata[i*ENT_W + TAG_W +: RANK_W] < ur) begin
        upd_row[i*ENT_W + TAG_W +: RANK_W] = rdata[i*ENT_W + TAG_W +: RANK_W] + RANK_W'(1);
      end
    end
    upd_row[uw*ENT_W + TAG_W +: RANK_W] = '0;
  end

  // dirty valid lines of a row read during flush
  always_comb begin
    dirty_cnt = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      dirty_cnt = dirty_cnt + (NW_W+1)'(rdata[i*ENT_W + ENT_W - 1] && rdata[i*ENT_W + ENT_W - 2]);
    end
  end

  logic [PROD_W-1:0] prod;
  assign prod = PROD_W'(cnt_q) * PROD_W'(bw);

  always_comb begin
    state_d    = state_q;
    tag_d      = tag_q;
    row_d      = row_q;
    ctr_d      = ctr_q;
    cnt_d      = cnt_q;
    words_d    = words_q;
    re         = 1'b0;
    we         = 1'b0;
    raddr      = row_q;
    waddr      = row_q;
    wdata      = '0;
    scan_start = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = ctr_q;
        ctr_d = ctr_q + ROW_W'(1);
        if (ctr_q == {ROW_W{1'b1}}) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (func_e'(func_i) == FUNC_FLUSH) begin
            ctr_d   = '0;
            cnt_d   = '0;
            state_d = ST_FLUSH;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        row_d      = {half, set_idx};
        tag_d      = sh_tag[TAG_W-1:0];
        re         = 1'b1;
        raddr      = {half, set_idx};
        scan_start = 1'b1;
        state_d    = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        we      = do_write;
        wdata   = upd_row;
        words_d = 21'(acc_words);
        state_d = ST_OUT;
      end
      ST_FLUSH: begin
        re    = 1'b1;
        raddr = ctr_q;
        we    = 1'b1;
        waddr = ctr_q;
        ctr_d = ctr_q + ROW_W'(1);
        if (ctr_q != '0) begin
          cnt_d = cnt_q + CNT_W'(dirty_cnt);
        end
        if (ctr_q == {ROW_W{1'b1}}) begin
          state_d = ST_FLUSH_END;
        end
      end
      ST_FLUSH_END: begin
        cnt_d   = cnt_q + CNT_W'(dirty_cnt);
        state_d = ST_MUL;
      end
      ST_MUL: begin
        words_d = 21'(prod);
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      ctr_q   <= '0;
    end else begin
      state_q <= state_d;
      ctr_q   <= ctr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q   <= tag_d;
    row_q   <= row_d;
    cnt_q   <= cnt_d;
    words_q <= words_d;
    if (state_q == ST_IDLE && in_valid_i) begin
      func_q <= func_i;
      addr_q <= addr_i;
    end
    if (state_q == ST_UPDATE) begin
      hit_q   <= hit_d;
      miss_q  <= miss_d;
      repl_q  <= repl_d;
      fetch_q <= fetch_d;
    end else if (state_q == ST_MUL) begin
      hit_q   <= 1'b0;
      miss_q  <= 1'b0;
      repl_q  <= 1'b0;
      fetch_q <= 1'b0;
    end
  end

  salc_tag_ram #(
    .ROW_W  (ROW_W),
    .DATA_W (ROW_D)
  ) u_ram (
    .clk_i   (clk_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata)
  );

  salc_way_scan #(
    .MAX_WAYS (MAX_WAYS),
    .TAG_W    (TAG_W),
    .RANK_W   (RANK_W),
    .NW_W     (NW_W),
    .WAY_W    (WAY_W)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scan_start),
    .row_i   (rdata),
    .tag_i   (tag_q),
    .nw_i    (nw),
    .done_o  (scan_done),
    .res_o   (sres)
  );

  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = (state_q == ST_OUT);
  assign hit_o             = hit_q;
  assign miss_o            = miss_q;
  assign replaced_o        = repl_q;
  assign fetched_o         = fetch_q;
  assign copy_back_words_o = words_q;

endmodule

[design/salc_tag_ram.sv]
// Set row memory: tags, valid, dirty and LRU rank of all ways of one set.
`timescale 1ns / 1ps
module salc_tag_ram #(
  parameter int unsigned ROW_W  = 11,
  parameter int unsigned DATA_W = 280
) (
  input  logic              clk_i,
  input  logic              re_i,
  input  logic [ROW_W-1:0]  raddr_i,
  output logic [DATA_W-1:0] rdata_o,
  input  logic              we_i,
  input  logic [ROW_W-1:0]  waddr_i,
  input  logic [DATA_W-1:0] wdata_i
);

  logic [DATA_W-1:0] mem_q [2**ROW_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/salc_way_scan.sv]
// Shared tag compare unit, steps through the ways of a set one per cycle.
`timescale 1ns / 1ps
module salc_way_scan #(
  parameter int unsigned MAX_WAYS = 8,
  parameter int unsigned TAG_W    = 30,
  parameter int unsigned RANK_W   = 4,
  parameter int unsigned NW_W     = 4,
  parameter int unsigned WAY_W    = 3
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [MAX_WAYS*(TAG_W+RANK_W+2)-1:0]  row_i,
  input  logic [TAG_W-1:0]                      tag_i,
  input  logic [NW_W-1:0]                       nw_i,
  output logic                                  done_o,
  output salc_pkg::scan_res_t                   res_o
);
  import salc_pkg::*;

  localparam int unsigned ENT_W = TAG_W + RANK_W + 2;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [WAY_W-1:0]  w_q, w_d;
  logic [RANK_W-1:0] best_rank_q, best_rank_d;
  scan_res_t         res_q, res_d;
  logic [ENT_W-1:0]  ent;
  logic              last;

  always_comb begin
    ent  = row_i[w_q*ENT_W +: ENT_W];
    last = (NW_W'(w_q) == nw_i - NW_W'(1));
    busy_d      = busy_q;
    done_d      = 1'b0;
    w_d         = w_q;
    best_rank_d = best_rank_q;
    res_d       = res_q;
    if (start_i) begin
      busy_d = 1'b1;
      w_d    = '0;
      res_d  = '0;
    end else if (busy_q) begin
      if (ent[ENT_W-1] && ent[TAG_W-1:0] == tag_i && !res_q.found) begin
        res_d.found   = 1'b1;
        res_d.hit_way = WAY_IDX_W'(w_q);
      end
      if (!ent[ENT_W-1] && !res_q.inv_found) begin
        res_d.inv_found = 1'b1;
        res_d.inv_way   = WAY_IDX_W'(w_q);
      end
      if (w_q == '0 || ent[TAG_W +: RANK_W] > best_rank_q) begin
        res_d.best_way = WAY_IDX_W'(w_q);
        best_rank_d    = ent[TAG_W +: RANK_W];
      end
      w_d = w_q + WAY_W'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q         <= w_d;
    best_rank_q <= best_rank_d;
    res_q       <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
